### rtl/core/lcr_pkg.sv
// Shared types, widths and helpers for the line clipper pipeline.
// Holds the parameter record, the point descriptors and the divider beat.
// No dependencies.
package lcr_pkg;

  localparam int FRAC_BITS = 8;
  localparam int IN_W      = 24;
  localparam int OUT_W     = 16;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS_CLIP = 2'd2;

  // Divider: one quotient bit per stage, enough bits to detect saturation.
  localparam int DIV_STEPS = OUT_W;
  localparam int NUM_W     = 2 * IN_W + 4;
  localparam int N_W       = NUM_W + 2;
  localparam int DEN_W     = IN_W + FRAC_BITS + 1;
  // Lane depth: product, sum, dividend set-up, divider steps, saturation.
  localparam int LANE_LAT  = 3 + DIV_STEPS + 1;

  typedef logic signed [IN_W-1:0]    coord_t;
  typedef logic signed [IN_W:0]      diff_t;
  typedef logic        [IN_W-1:0]    mag_t;
  typedef logic signed [OUT_W-1:0]   pix_t;
  typedef logic signed [2*IN_W+1:0]  prod_t;
  typedef logic signed [2*IN_W:0]    bprod_t;
  typedef logic signed [NUM_W-1:0]   num_t;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_REJECT = 2'd0;
  localparam mode_t MODE_PASS   = 2'd1;
  localparam mode_t MODE_CLIP   = 2'd2;

  // Parameter t = n / d with d > 0, or a signed infinity.
  typedef struct packed {
    logic  inf;
    logic  neg;
    diff_t n;
    mag_t  d;
  } tpar_t;

  // One output coordinate: base, or base + delta * tn / td when rat is set.
  typedef struct packed {
    logic   rat;
    coord_t base;
    diff_t  delta;
    diff_t  tn;
    mag_t   td;
  } pcoord_t;

  typedef struct packed {
    logic   valid;
    mode_t  mode;
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
    diff_t  dx;
    diff_t  dy;
    coord_t xin;
    coord_t xout;
    coord_t yin;
    coord_t yout;
    tpar_t  tinx;
    tpar_t  tiny;
    tpar_t  toutx;
    tpar_t  touty;
    logic   in_gt;
    logic   out_lt;
    tpar_t  tin2;
    tpar_t  tout1;
    logic   tin1_gt_one;
    logic   corner;
    logic   tin2_gt_one;
    logic   tin2_gt_zero;
    logic   tout1_gt_zero;
    logic   tout1_lt_one;
  } clip_t;

  typedef struct packed {
    logic    valid;
    logic    vis;
    pcoord_t sx;
    pcoord_t sy;
    pcoord_t ex;
    pcoord_t ey;
  } seg_t;

  // Divider beat: lo holds the remaining dividend bits on top, quotient below.
  typedef struct packed {
    logic                 neg;
    logic                 sat;
    logic [DEN_W-1:0]     rem;
    logic [DIV_STEPS-1:0] lo;
    logic [DEN_W-1:0]     den;
  } div_t;

  function automatic prod_t mul_nd(diff_t n, mag_t d);
    return prod_t'(n) * prod_t'(signed'({1'b0, d}));
  endfunction

  function automatic logic signed [1:0] t_key(tpar_t t);
    logic signed [1:0] k;
    k = 2'sd0;
    if (t.inf) k = t.neg ? -2'sd1 : 2'sd1;
    return k;
  endfunction

  // a < b; pab = a.n * b.d, pba = b.n * a.d
  function automatic logic t_less(tpar_t a, tpar_t b, prod_t pab, prod_t pba);
    logic signed [1:0] ka;
    logic signed [1:0] kb;
    logic              lt;
    ka = t_key(a);
    kb = t_key(b);
    if (ka != kb) lt = (ka < kb);
    else if (ka != 2'sd0) lt = 1'b0;
    else lt = (pab < pba);
    return lt;
  endfunction

endpackage

### rtl/core/lcr_param.sv
// Front of the clipper: input register, outcodes and parameters, cross
// products, ordering of the entry and exit parameters. Uses lcr_pkg.
module lcr_param (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [lcr_pkg::CFG_W-1:0]   cfg_width,
  input  logic [lcr_pkg::CFG_W-1:0]   cfg_height,
  input  logic                        cfg_bypass,
  input  logic                        in_valid,
  input  lcr_pkg::coord_t             in_x1,
  input  lcr_pkg::coord_t             in_y1,
  input  lcr_pkg::coord_t             in_x2,
  input  lcr_pkg::coord_t             in_y2,
  output lcr_pkg::clip_t              clip_o
);
  import lcr_pkg::*;

  logic   in_valid_r;
  coord_t x1_r, y1_r, x2_r, y2_r;
  clip_t  a_r, a_nxt;
  clip_t  b_r;
  prod_t  pin_a_r, pin_b_r, pout_a_r, pout_b_r;
  clip_t  c_r, c_nxt;

  coord_t     wq, hq;
  diff_t      dx, dy;
  logic       sxp, syp;
  logic [3:0] cs, ce;

  function automatic tpar_t make_t(diff_t num, diff_t delta, logic zpos);
    tpar_t t;
    diff_t ad;
    t.inf = 1'b0;
    t.neg = 1'b0;
    t.n   = '0;
    t.d   = mag_t'(1);
    ad    = delta[IN_W] ? -delta : delta;
    if (delta != '0) begin
      t.n = delta[IN_W] ? -num : num;
      t.d = ad[IN_W-1:0];
    end else if (num != '0) begin
      t.inf = 1'b1;
      t.neg = num[IN_W] ^ ~zpos;
    end
    return t;
  endfunction

  function automatic logic gt_one(tpar_t t);
    return (t.inf && !t.neg) || (!t.inf && (t.n > signed'({1'b0, t.d})));
  endfunction

  function automatic logic gt_zero(tpar_t t);
    return (t.inf && !t.neg) || (!t.inf && (t.n > 0));
  endfunction

  function automatic logic lt_one(tpar_t t);
    return (t.inf && t.neg) || (!t.inf && (t.n < signed'({1'b0, t.d})));
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    x1_r <= in_x1;
    y1_r <= in_y1;
    x2_r <= in_x2;
    y2_r <= in_y2;
  end

  // Outcodes, deltas and the four parameters.
  always_comb begin
    wq  = coord_t'({cfg_width, {FRAC_BITS{1'b0}}});
    hq  = coord_t'({cfg_height, {FRAC_BITS{1'b0}}});
    dx  = diff_t'(x2_r) - diff_t'(x1_r);
    dy  = diff_t'(y2_r) - diff_t'(y1_r);
    sxp = (dx > 0) || ((dx == '0) && (x1_r <= 0));
    syp = (dy > 0) || ((dy == '0) && (y1_r <= 0));
    cs  = {y1_r > hq, y1_r < 0, x1_r > wq, x1_r < 0};
    ce  = {y2_r > hq, y2_r < 0, x2_r > wq, x2_r < 0};

    a_nxt       = '0;
    a_nxt.valid = in_valid_r;
    a_nxt.x1    = x1_r;
    a_nxt.y1    = y1_r;
    a_nxt.x2    = x2_r;
    a_nxt.y2    = y2_r;
    a_nxt.dx    = dx;
    a_nxt.dy    = dy;
    a_nxt.xin   = sxp ? '0 : wq;
    a_nxt.xout  = sxp ? wq : '0;
    a_nxt.yin   = syp ? '0 : hq;
    a_nxt.yout  = syp ? hq : '0;
    a_nxt.tinx  = make_t(diff_t'(a_nxt.xin) - diff_t'(x1_r), dx, sxp);
    a_nxt.tiny  = make_t(diff_t'(a_nxt.yin) - diff_t'(y1_r), dy, syp);
    a_nxt.toutx = make_t(diff_t'(a_nxt.xout) - diff_t'(x1_r), dx, sxp);
    a_nxt.touty = make_t(diff_t'(a_nxt.yout) - diff_t'(y1_r), dy, syp);
    if (cfg_bypass) a_nxt.mode = MODE_PASS;
    else if ((cs & ce) != 4'd0) a_nxt.mode = MODE_REJECT;
    else if ((cs | ce) == 4'd0) a_nxt.mode = MODE_PASS;
    else a_nxt.mode = MODE_CLIP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0;
      b_r <= '0;
      c_r <= '0;
    end else begin
      a_r <= a_nxt;
      b_r <= a_r;
      c_r <= c_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pin_a_r  <= mul_nd(a_r.tinx.n, a_r.tiny.d);
    pin_b_r  <= mul_nd(a_r.tiny.n, a_r.tinx.d);
    pout_a_r <= mul_nd(a_r.toutx.n, a_r.touty.d);
    pout_b_r <= mul_nd(a_r.touty.n, a_r.toutx.d);
  end

  // Order the entry pair and the exit pair, test against zero and one.
  always_comb begin
    logic  in_lt;
    tpar_t tin1;
    in_lt               = t_less(b_r.tinx, b_r.tiny, pin_a_r, pin_b_r);
    c_nxt               = b_r;
    c_nxt.in_gt         = t_less(b_r.tiny, b_r.tinx, pin_b_r, pin_a_r);
    c_nxt.out_lt        = t_less(b_r.toutx, b_r.touty, pout_a_r, pout_b_r);
    tin1                = in_lt ? b_r.tinx : b_r.tiny;
    c_nxt.tin2          = in_lt ? b_r.tiny : b_r.tinx;
    c_nxt.tout1         = c_nxt.out_lt ? b_r.toutx : b_r.touty;
    c_nxt.tin1_gt_one   = gt_one(tin1);
    c_nxt.corner        = gt_zero(tin1);
    c_nxt.tin2_gt_one   = gt_one(c_nxt.tin2);
    c_nxt.tin2_gt_zero  = gt_zero(c_nxt.tin2);
    c_nxt.tout1_gt_zero = gt_zero(c_nxt.tout1);
    c_nxt.tout1_lt_one  = lt_one(c_nxt.tout1);
  end

  assign clip_o = c_r;

endmodule

### rtl/core/lcr_select.sv
// Case selection: compares entry against exit and builds the two output
// points as plain or parametric coordinates. Uses lcr_pkg.
module lcr_select (
  input  logic           clk,
  input  logic           rst_n,
  input  lcr_pkg::clip_t clip_i,
  output lcr_pkg::seg_t  seg_o
);
  import lcr_pkg::*;

  clip_t d_r;
  prod_t pa_r, pb_r;
  seg_t  e_r, e_nxt;

  function automatic pcoord_t plain(coord_t v);
    pcoord_t c;
    c      = '0;
    c.base = v;
    c.td   = mag_t'(1);
    return c;
  endfunction

  function automatic pcoord_t along(coord_t base, diff_t delta, tpar_t t);
    pcoord_t c;
    c.rat   = (delta != '0) && !t.inf;
    c.base  = base;
    c.delta = delta;
    c.tn    = t.n;
    c.td    = t.d;
    return c;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r <= '0;
      e_r <= '0;
    end else begin
      d_r <= clip_i;
      e_r <= e_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pa_r <= mul_nd(clip_i.tin2.n, clip_i.tout1.d);
    pb_r <= mul_nd(clip_i.tout1.n, clip_i.tin2.d);
  end

  always_comb begin
    logic    le;
    pcoord_t in_x, in_y, out_x, out_y, cr_x, cr_y;
    le = !t_less(d_r.tout1, d_r.tin2, pb_r, pa_r);
    if (d_r.in_gt) begin
      in_x = plain(d_r.xin);
      in_y = along(d_r.y1, d_r.dy, d_r.tinx);
      cr_x = plain(d_r.xin);
      cr_y = plain(d_r.yout);
    end else begin
      in_x = along(d_r.x1, d_r.dx, d_r.tiny);
      in_y = plain(d_r.yin);
      cr_x = plain(d_r.xout);
      cr_y = plain(d_r.yin);
    end
    if (!d_r.tout1_lt_one) begin
      out_x = plain(d_r.x2);
      out_y = plain(d_r.y2);
    end else if (d_r.out_lt) begin
      out_x = plain(d_r.xout);
      out_y = along(d_r.y1, d_r.dy, d_r.toutx);
    end else begin
      out_x = along(d_r.x1, d_r.dx, d_r.touty);
      out_y = plain(d_r.yout);
    end

    e_nxt.valid = d_r.valid;
    e_nxt.vis   = 1'b1;
    e_nxt.sx    = plain(d_r.x1);
    e_nxt.sy    = plain(d_r.y1);
    e_nxt.ex    = plain(d_r.x2);
    e_nxt.ey    = plain(d_r.y2);
    unique case (d_r.mode)
      MODE_REJECT: e_nxt.vis = 1'b0;
      MODE_PASS: ;
      MODE_CLIP: begin
        if (d_r.tin1_gt_one) begin
          e_nxt.vis = 1'b0;
        end else if (d_r.tin2_gt_one || !(d_r.tin2_gt_zero || d_r.tout1_gt_zero)) begin
          // only the corner, if any, survives
          if (d_r.corner) begin
            e_nxt.ex = plain(d_r.xin);
            e_nxt.ey = plain(d_r.yin);
          end else begin
            e_nxt.vis = 1'b0;
          end
        end else if (le) begin
          if (d_r.tin2_gt_zero) begin
            e_nxt.sx = in_x;
            e_nxt.sy = in_y;
          end else if (d_r.corner) begin
            e_nxt.sx = plain(d_r.xin);
            e_nxt.sy = plain(d_r.yin);
          end
          e_nxt.ex = out_x;
          e_nxt.ey = out_y;
        end else begin
          if (d_r.corner) begin
            e_nxt.sx = plain(d_r.xin);
            e_nxt.sy = plain(d_r.yin);
          end
          e_nxt.ex = cr_x;
          e_nxt.ey = cr_y;
        end
      end
      default: e_nxt.vis = 1'b0;
    endcase
  end

  assign seg_o = e_r;

endmodule

### rtl/core/lcr_point.sv
// One coordinate lane, front half: numerator of base + delta * t, its
// magnitude, and the rounding dividend and divisor. Uses lcr_pkg.
module lcr_point (
  input  logic             clk,
  input  lcr_pkg::pcoord_t coord_i,
  output lcr_pkg::div_t    div_o
);
  import lcr_pkg::*;

  bprod_t           p1_r;
  prod_t            p2_r;
  logic             rat_r;
  coord_t           base_r;
  mag_t             td_r;
  logic [NUM_W-1:0] mag_r;
  logic             neg_r;
  mag_t             den_r;
  div_t             div_r;

  num_t             num;
  logic [N_W-1:0]   n_full;
  logic [DEN_W-1:0] d_full;
  div_t             div_nxt;

  always_ff @(posedge clk) begin
    p1_r   <= bprod_t'(signed'({1'b0, coord_i.td})) * bprod_t'(coord_i.base);
    p2_r   <= prod_t'(coord_i.delta) * prod_t'(coord_i.tn);
    rat_r  <= coord_i.rat;
    base_r <= coord_i.base;
    td_r   <= coord_i.td;
  end

  assign num = rat_r ? (num_t'(p1_r) + num_t'(p2_r)) : num_t'(base_r);

  always_ff @(posedge clk) begin
    mag_r <= num[NUM_W-1] ? unsigned'(-num) : unsigned'(num);
    neg_r <= num[NUM_W-1];
    den_r <= rat_r ? td_r : mag_t'(1);
  end

  // Round half away: q = (2|n| + d') / (2d') with d' = den scaled to Q units.
  always_comb begin
    n_full      = {1'b0, mag_r, 1'b0} + N_W'({den_r, {FRAC_BITS{1'b0}}});
    d_full      = {den_r, {(FRAC_BITS + 1){1'b0}}};
    div_nxt.neg = neg_r;
    div_nxt.sat = n_full[N_W-1:DIV_STEPS] >= (N_W - DIV_STEPS)'(d_full);
    div_nxt.rem = n_full[DIV_STEPS +: DEN_W];
    div_nxt.lo  = n_full[DIV_STEPS-1:0];
    div_nxt.den = d_full;
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
  end

  assign div_o = div_r;

endmodule

### rtl/core/lcr_div.sv
// One coordinate lane, back half: restoring divider, one quotient bit per
// stage, then sign and 16-bit saturation. Uses lcr_pkg.
module lcr_div (
  input  logic          clk,
  input  lcr_pkg::div_t div_i,
  output lcr_pkg::pix_t pix_o
);
  import lcr_pkg::*;

  localparam pix_t PIX_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
  localparam pix_t PIX_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

  div_t st_r [1:DIV_STEPS];
  pix_t pix_r;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
    div_t           src;
    div_t           nxt;
    logic [DEN_W:0] rem_sh;
    logic [DEN_W:0] rem_sub;
    logic           ge;

    if (g == 0) begin : g_first
      assign src = div_i;
    end else begin : g_rest
      assign src = st_r[g];
    end

    always_comb begin
      rem_sh  = {src.rem, src.lo[DIV_STEPS-1]};
      rem_sub = rem_sh - {1'b0, src.den};
      ge      = rem_sh >= {1'b0, src.den};
      nxt     = src;
      nxt.rem = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      nxt.lo  = {src.lo[DIV_STEPS-2:0], ge};
    end

    always_ff @(posedge clk) begin
      st_r[g+1] <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r[DIV_STEPS].sat || st_r[DIV_STEPS].lo[OUT_W-1]) begin
      pix_r <= st_r[DIV_STEPS].neg ? PIX_MIN : PIX_MAX;
    end else if (st_r[DIV_STEPS].neg) begin
      pix_r <= -pix_t'(st_r[DIV_STEPS].lo);
    end else begin
      pix_r <= pix_t'(st_r[DIV_STEPS].lo);
    end
  end

  assign pix_o = pix_r;

endmodule

### rtl/core/line_clip_to_rectangle.sv
// Line clipper top level: config registers, front pipeline, four coordinate
// lanes, output register. Uses lcr_pkg, lcr_param, lcr_select, lcr_point, lcr_div.
//
// Takes one segment per clock (start high; busy is never raised) and gives
// one result beat per segment, marked by out_strobe. Between the accepting
// edge and the beat lie four front stages (input, outcodes and parameters,
// cross products, ordering), two selection stages, and twenty stages in each
// coordinate lane, of which sixteen are the one-bit-per-stage divider that
// rounds the clipped coordinate to whole pixels, then the output register.
// A fresh segment may follow every cycle. The receiver cannot hold results
// off, so take every beat on the cycle it is shown. A rejected segment comes
// out with out_visible low and all four coordinates zero. Write the clip
// rectangle and bypass only while no segment is in flight.
module line_clip_to_rectangle (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lcr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lcr_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                            start,
  output logic                            busy,
  input  lcr_pkg::coord_t                 in_start_x,
  input  lcr_pkg::coord_t                 in_start_y,
  input  lcr_pkg::coord_t                 in_end_x,
  input  lcr_pkg::coord_t                 in_end_y,
  output logic                            out_strobe,
  output logic                            out_visible,
  output lcr_pkg::pix_t                   out_start_x,
  output lcr_pkg::pix_t                   out_start_y,
  output lcr_pkg::pix_t                   out_end_x,
  output lcr_pkg::pix_t                   out_end_y
);
  import lcr_pkg::*;

  // Register stages from the accepting edge to the result beat.
  localparam int FRONT_LAT = 4;
  localparam int SEL_LAT   = 2;
  localparam int TOTAL_LAT = FRONT_LAT + SEL_LAT + LANE_LAT + 1;

  typedef struct packed {
    logic valid;
    logic vis;
  } tag_t;

  logic [CFG_W-1:0] clip_width_r;
  logic [CFG_W-1:0] clip_height_r;
  logic             bypass_clip_r;

  logic    accept;
  clip_t   clip;
  seg_t    seg;
  pcoord_t lane_coord [4];
  pix_t    lane_pix   [4];
  tag_t    tag_r      [LANE_LAT];

  logic out_strobe_r, out_visible_r;
  pix_t out_start_x_r, out_start_y_r, out_end_x_r, out_end_y_r;

  // Config writes: drop an index beyond the register list.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_width_r  <= '0;
      clip_height_r <= '0;
      bypass_clip_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CLIP_WIDTH:  clip_width_r  <= cfg_wdata;
        CFG_CLIP_HEIGHT: clip_height_r <= cfg_wdata;
        CFG_BYPASS_CLIP: bypass_clip_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // The pipeline advances every cycle, so a beat is always taken.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  lcr_param u_param (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_width  (clip_width_r),
    .cfg_height (clip_height_r),
    .cfg_bypass (bypass_clip_r),
    .in_valid   (accept),
    .in_x1      (in_start_x),
    .in_y1      (in_start_y),
    .in_x2      (in_end_x),
    .in_y2      (in_end_y),
    .clip_o     (clip)
  );

  lcr_select u_select (
    .clk    (clk),
    .rst_n  (rst_n),
    .clip_i (clip),
    .seg_o  (seg)
  );

  // Four identical lanes: start x, start y, end x, end y.
  assign lane_coord[0] = seg.sx;
  assign lane_coord[1] = seg.sy;
  assign lane_coord[2] = seg.ex;
  assign lane_coord[3] = seg.ey;

  for (genvar l = 0; l < 4; l++) begin : g_lane
    div_t div_beat;

    lcr_point u_point (
      .clk     (clk),
      .coord_i (lane_coord[l]),
      .div_o   (div_beat)
    );

    lcr_div u_div (
      .clk   (clk),
      .div_i (div_beat),
      .pix_o (lane_pix[l])
    );
  end

  // Carry valid and visible alongside the lanes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANE_LAT; i++) tag_r[i] <= '0;
    end else begin
      tag_r[0] <= '{valid: seg.valid, vis: seg.vis};
      for (int i = 1; i < LANE_LAT; i++) tag_r[i] <= tag_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r  <= 1'b0;
      out_visible_r <= 1'b0;
    end else begin
      out_strobe_r  <= tag_r[LANE_LAT-1].valid;
      out_visible_r <= tag_r[LANE_LAT-1].valid && tag_r[LANE_LAT-1].vis;
    end
  end

  // Zero the coordinates of a rejected segment.
  always_ff @(posedge clk) begin
    out_start_x_r <= tag_r[LANE_LAT-1].vis ? lane_pix[0] : '0;
    out_start_y_r <= tag_r[LANE_LAT-1].vis ? lane_pix[1] : '0;
    out_end_x_r   <= tag_r[LANE_LAT-1].vis ? lane_pix[2] : '0;
    out_end_y_r   <= tag_r[LANE_LAT-1].vis ? lane_pix[3] : '0;
  end

  assign out_strobe  = out_strobe_r;
  assign out_visible = out_visible_r;
  assign out_start_x = out_start_x_r;
  assign out_start_y = out_start_y_r;
  assign out_end_x   = out_end_x_r;
  assign out_end_y   = out_end_y_r;

  // Every accepted segment yields a beat after the full pipeline depth.
  a_accept_to_beat: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##TOTAL_LAT out_strobe)
    else $error("accepted segment produced no result beat");

  // A segment rejected at selection leaves the lanes as a zeroed, invisible beat.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (seg.valid && !seg.vis) |-> ##(LANE_LAT + 1)
      (out_strobe && !out_visible && out_start_x == '0 && out_start_y == '0 &&
       out_end_x == '0 && out_end_y == '0))
    else $error("rejected segment not delivered as a zeroed beat");

endmodule

### dv/lcr_clip_checker.sv
// Checker for the line clipper: tracks the clip registers, predicts each result
// beat from the accepted segment and compares it with what the block emits.
// Depends on lcr_pkg for widths and register indexes.
module lcr_clip_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lcr_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          start,
  input  logic                          busy,
  input  lcr_pkg::coord_t               in_start_x,
  input  lcr_pkg::coord_t               in_start_y,
  input  lcr_pkg::coord_t               in_end_x,
  input  lcr_pkg::coord_t               in_end_y,
  input  logic                          out_strobe,
  input  logic                          out_visible,
  input  lcr_pkg::pix_t                 out_start_x,
  input  lcr_pkg::pix_t                 out_start_y,
  input  lcr_pkg::pix_t                 out_end_x,
  input  lcr_pkg::pix_t                 out_end_y,
  output int                            n_fail,
  output int                            n_pending
);
  import lcr_pkg::*;

  typedef struct {
    int     k;
    longint n;
    longint d;
  } tval_t;

  typedef struct {
    longint xn;
    longint xd;
    longint yn;
    longint yd;
  } rpt_t;

  typedef struct {
    int   np;
    rpt_t p0;
    rpt_t p1;
    rpt_t p2;
  } cut_t;

  typedef struct {
    logic vis;
    pix_t sx;
    pix_t sy;
    pix_t ex;
    pix_t ey;
  } seg_beat_t;

  logic [CFG_W-1:0] width_q;
  logic [CFG_W-1:0] height_q;
  logic             bypass_q;
  seg_beat_t        expected_segs[$];

  function automatic int t_order(tval_t a, tval_t b);
    longint l;
    longint r;
    if (a.k != b.k) return (a.k < b.k) ? -1 : 1;
    if (a.k != 0) return 0;
    l = a.n * b.d;
    r = b.n * a.d;
    return (l < r) ? -1 : ((l > r) ? 1 : 0);
  endfunction

  // Zero delta with a nonzero num gives an infinity of sign num times zs.
  function automatic tval_t t_of(longint num, longint delta, int zs);
    tval_t t;
    t.k = 0;
    t.n = 0;
    t.d = 1;
    if (delta != 0) begin
      t.n = (delta < 0) ? -num : num;
      t.d = (delta < 0) ? -delta : delta;
    end else if (num != 0) begin
      t.k = ((num > 0) ? 1 : -1) * zs;
    end
    return t;
  endfunction

  function automatic void walk(longint base, longint delta, tval_t t,
                               output longint n, output longint d);
    if (delta == 0 || t.k != 0) begin
      n = base;
      d = 1;
    end else begin
      n = base * t.d + delta * t.n;
      d = t.d;
    end
  endfunction

  function automatic pix_t to_pixel(longint num, longint den);
    longint unsigned dv;
    longint unsigned mag;
    longint unsigned q;
    pix_t            r;
    dv  = longint'(den) << FRAC_BITS;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q   = (2 * mag + dv) / (2 * dv);
    if (num < 0) r = (q > 32768) ? -16'sd32768 : pix_t'(-longint'(q));
    else r = (q > 32767) ? 16'sd32767 : pix_t'(q);
    return r;
  endfunction

  function automatic rpt_t pt(longint x, longint y);
    rpt_t p;
    p.xn = x;
    p.xd = 1;
    p.yn = y;
    p.yd = 1;
    return p;
  endfunction

  function automatic int zone(longint x, longint y, longint wq, longint hq);
    return (x < 0 ? 1 : 0) | (x > wq ? 2 : 0) | (y < 0 ? 4 : 0) | (y > hq ? 8 : 0);
  endfunction

  function automatic cut_t cut_segment(longint x1, longint y1, longint x2, longint y2,
                                       longint wq, longint hq);
    tval_t  one;
    tval_t  zero;
    longint dx;
    longint dy;
    int     sx;
    int     sy;
    longint xin;
    longint xout;
    longint yin;
    longint yout;
    tval_t  tinx;
    tval_t  tiny;
    tval_t  tin1;
    tval_t  tin2;
    tval_t  toutx;
    tval_t  touty;
    tval_t  tout1;
    rpt_t   p;
    rpt_t   pts[3];
    cut_t   c;
    one  = '{0, 1, 1};
    zero = '{0, 0, 1};
    c.np = 0;
    dx = x2 - x1;
    dy = y2 - y1;
    sx = dx > 0 ? 1 : (dx < 0 ? -1 : (x1 > 0 ? -1 : 1));
    sy = dy > 0 ? 1 : (dy < 0 ? -1 : (y1 > 0 ? -1 : 1));
    xin  = sx > 0 ? 0 : wq;
    xout = sx > 0 ? wq : 0;
    yin  = sy > 0 ? 0 : hq;
    yout = sy > 0 ? hq : 0;
    tinx = t_of(xin - x1, dx, sx);
    tiny = t_of(yin - y1, dy, sy);
    if (t_order(tinx, tiny) < 0) begin
      tin1 = tinx;
      tin2 = tiny;
    end else begin
      tin1 = tiny;
      tin2 = tinx;
    end
    if (t_order(tin1, one) > 0) return c;
    // Entry on both axes after the start: emit the entry corner first.
    if (t_order(tin1, zero) > 0) begin
      pts[c.np] = pt(xin, yin);
      c.np = c.np + 1;
    end
    if (t_order(tin2, one) <= 0) begin
      toutx = t_of(xout - x1, dx, sx);
      touty = t_of(yout - y1, dy, sy);
      tout1 = (t_order(toutx, touty) < 0) ? toutx : touty;
      if (t_order(tin2, zero) > 0 || t_order(tout1, zero) > 0) begin
        if (t_order(tin2, tout1) <= 0) begin
          if (t_order(tin2, zero) > 0) begin
            if (t_order(tinx, tiny) > 0) begin
              p = pt(xin, 0);
              walk(y1, dy, tinx, p.yn, p.yd);
            end else begin
              p = pt(0, yin);
              walk(x1, dx, tiny, p.xn, p.xd);
            end
            pts[c.np] = p;
            c.np = c.np + 1;
          end
          if (t_order(tout1, one) < 0) begin
            if (t_order(toutx, touty) < 0) begin
              p = pt(xout, 0);
              walk(y1, dy, toutx, p.yn, p.yd);
            end else begin
              p = pt(0, yout);
              walk(x1, dx, touty, p.xn, p.xd);
            end
          end else begin
            p = pt(x2, y2);
          end
          pts[c.np] = p;
          c.np = c.np + 1;
        end else begin
          pts[c.np] = (t_order(tinx, tiny) > 0) ? pt(xin, yout) : pt(xout, yin);
          c.np = c.np + 1;
        end
      end
    end
    c.p0 = pts[0];
    c.p1 = pts[1];
    c.p2 = pts[2];
    return c;
  endfunction

  function automatic seg_beat_t predict_segment(coord_t ax, coord_t ay, coord_t bx,
                                                coord_t by);
    longint    x1;
    longint    y1;
    longint    x2;
    longint    y2;
    longint    wq;
    longint    hq;
    int        cs;
    int        ce;
    rpt_t      s;
    rpt_t      e;
    cut_t      c;
    seg_beat_t r;
    x1 = ax;
    y1 = ay;
    x2 = bx;
    y2 = by;
    wq = longint'(width_q) << FRAC_BITS;
    hq = longint'(height_q) << FRAC_BITS;
    s = pt(x1, y1);
    e = pt(x2, y2);
    r = '{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
    if (!bypass_q) begin
      cs = zone(x1, y1, wq, hq);
      ce = zone(x2, y2, wq, hq);
      if ((cs & ce) != 0) return r;
      if ((cs | ce) != 0) begin
        c = cut_segment(x1, y1, x2, y2, wq, hq);
        if (c.np == 0) return r;
        if (c.np == 1) e = c.p0;
        else if (c.np == 2) begin
          s = c.p0;
          e = c.p1;
        end else begin
          // Drop the leading corner; keep entry and exit.
          s = c.p1;
          e = c.p2;
        end
      end
    end
    r.vis = 1'b1;
    r.sx  = to_pixel(s.xn, s.xd);
    r.sy  = to_pixel(s.yn, s.yd);
    r.ex  = to_pixel(e.xn, e.xd);
    r.ey  = to_pixel(e.yn, e.yd);
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    n_fail++;
  endtask

  initial n_fail = 0;
  assign n_pending = expected_segs.size();

  always @(posedge clk) begin
    seg_beat_t w;
    if (!rst_n) begin
      width_q  <= '0;
      height_q <= '0;
      bypass_q <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CLIP_WIDTH:  width_q  <= cfg_wdata;
          CFG_CLIP_HEIGHT: height_q <= cfg_wdata;
          CFG_BYPASS_CLIP: bypass_q <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (start && !busy)
        expected_segs.push_back(predict_segment(in_start_x, in_start_y, in_end_x, in_end_y));
      if (out_strobe) begin
        if (expected_segs.size() == 0) begin
          report("unexpected beat", out_visible, 0);
        end else begin
          w = expected_segs.pop_front();
          if (out_visible !== w.vis) report("visible", out_visible, w.vis);
          if (out_start_x !== w.sx) report("start_x", out_start_x, w.sx);
          if (out_start_y !== w.sy) report("start_y", out_start_y, w.sy);
          if (out_end_x !== w.ex) report("end_x", out_end_x, w.ex);
          if (out_end_y !== w.ey) report("end_y", out_end_y, w.ey);
        end
      end
    end
  end

endmodule

### dv/tb_line_clip_to_rectangle.sv
// Testbench top for the line clipper: clock, reset, register phases and
// segment stimulus, with lcr_clip_checker doing prediction and comparison.
// Depends on lcr_pkg, line_clip_to_rectangle and lcr_clip_checker.
module tb_line_clip_to_rectangle;
  import lcr_pkg::*;

  localparam int     PIPE_DEPTH  = 27;
  localparam longint CYCLE_LIMIT = 400000;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  logic             start;
  logic             busy;
  coord_t           in_start_x;
  coord_t           in_start_y;
  coord_t           in_end_x;
  coord_t           in_end_y;
  logic             out_strobe;
  logic             out_visible;
  pix_t             out_start_x;
  pix_t             out_start_y;
  pix_t             out_end_x;
  pix_t             out_end_y;
  int               n_fail;
  int               n_pending;
  longint           cycles;

  // Current rectangle in Q16.8, used to aim random points near the edges.
  int               rect_wq;
  int               rect_hq;

  line_clip_to_rectangle i_dut (.*);

  lcr_clip_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost beat ends the run here.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_W-1:0];
    @(posedge clk);
  endtask

  // Program the whole rectangle plus bypass; hold the enable across the burst.
  task automatic set_clip(int w, int h, bit byp);
    write_reg(CFG_CLIP_WIDTH, w);
    write_reg(CFG_CLIP_HEIGHT, h);
    write_reg(CFG_BYPASS_CLIP, byp);
    cfg_we  <= 1'b0;
    rect_wq = w << FRAC_BITS;
    rect_hq = h << FRAC_BITS;
  endtask

  // Let the pipe drain before touching the registers again.
  task automatic drain();
    while (n_pending != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  // Short gaps are common, long ones rare, and many beats go back to back.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic coord_t clamp24(longint v);
    if (v > 8388607) return 24'sh7FFFFF;
    if (v < -8388608) return -24'sh800000;
    return coord_t'(v);
  endfunction

  // Pick a coordinate: full range, near the rectangle, or exactly on an edge.
  function automatic coord_t pick_coord(int lim);
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return coord_t'($urandom());
    if (r < 8) return clamp24(longint'($urandom_range(0, 3 * lim + 1024)) - lim - 512);
    if (r == 8) return coord_t'(0);
    return clamp24(lim);
  endfunction

  // Offer one segment beat; lower start only if a gap follows.
  task automatic send_segment(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    int gap;
    in_start_x <= ax;
    in_start_y <= ay;
    in_end_x   <= bx;
    in_end_y   <= by;
    start      <= 1'b1;
    do @(posedge clk); while (busy);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(int count);
    for (int i = 0; i < count; i++)
      send_segment(pick_coord(rect_wq), pick_coord(rect_hq),
                   pick_coord(rect_wq), pick_coord(rect_hq));
    start <= 1'b0;
  endtask

  initial begin
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= '0;
    cfg_wdata  <= '0;
    start      <= 1'b0;
    in_start_x <= '0;
    in_start_y <= '0;
    in_end_x   <= '0;
    in_end_y   <= '0;
    rect_wq    = 0;
    rect_hq    = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats against a 640x480 rectangle.
    set_clip(640, 480, 1'b0);
    send_segment(24'sh000100, 24'sh000100, 24'sh010000, 24'sh008000);  // wholly inside
    send_segment(-24'sh000500, 24'sh000100, -24'sh000100, 24'sh010000); // off the left side
    send_segment(-24'sh001000, 24'sh001000, 24'sh040000, 24'sh001000);  // horizontal crossing
    send_segment(24'sh001000, -24'sh001000, 24'sh001000, 24'sh040000);  // vertical crossing
    send_segment(24'sh000000, -24'sh001000, 24'sh000000, 24'sh040000);  // on x = 0, zero dx
    send_segment(-24'sh010000, 24'sh030000, 24'sh030000, -24'sh010000); // cuts a corner region
    send_segment(-24'sh001000, -24'sh000800, 24'sh010000, 24'sh008000); // enters past a corner
    send_segment(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);   // max point
    send_segment(-24'sh800000, -24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF); // full diagonal
    send_segment(-24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, -24'sh800000); // anti-diagonal
    send_segment(24'sh028000, 24'sh01E000, 24'sh028000, 24'sh01E000);   // exact corner point
    send_segment(24'sh000080, 24'sh000180, -24'sh000080, 24'sh000280);  // half-pixel rounding
    send_segment(24'sh030000, 24'sh001000, -24'sh001000, 24'sh001000);  // right to left
    start <= 1'b0;
    drain();

    // Bypass: endpoints only rounded and saturated.
    set_clip(640, 480, 1'b1);
    send_segment(-24'sh800000, 24'sh7FFFFF, 24'sh000080, -24'sh000080);
    send_segment(-24'sh000180, 24'sh000280, 24'sh7FFF80, -24'sh7FFF80);
    send_random(80);
    drain();

    // Degenerate rectangle, then the largest one.
    set_clip(0, 0, 1'b0);
    send_segment(-24'sh000100, 24'sh000000, 24'sh000100, 24'sh000000);
    send_random(80);
    drain();
    set_clip(32767, 32767, 1'b0);
    send_random(110);
    drain();

    set_clip(640, 480, 1'b0);
    send_random(130);
    drain();
    set_clip(1, 300, 0);
    send_random(80);
    drain();
    set_clip($urandom_range(0, 32767), $urandom_range(0, 255), 1'b0);
    send_random(100);
    drain();

    if (n_fail == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/lcr_pkg.sv
rtl/core/lcr_param.sv
rtl/core/lcr_select.sv
rtl/core/lcr_point.sv
rtl/core/lcr_div.sv
rtl/core/line_clip_to_rectangle.sv
dv/lcr_clip_checker.sv
dv/tb_line_clip_to_rectangle.sv
